/* hdl/sidac_pkg.sv */
// Shared types, constants and the double-dabble step function for the
// signed integer to decimal ASCII unit. Depends on nothing.
package sidac_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned BcdW          = NumDigits * DigitW;
  localparam int unsigned CharW         = 8;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumDdStages   = ValueW / StepsPerStage;
  localparam int unsigned DigitIdxW     = $clog2(NumDigits);

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // One word in flight through the conversion pipeline.
  typedef struct packed {
    logic                neg;
    logic [ValueW-1:0]   bin;
    logic [BcdW-1:0]     bcd;
  } sidac_item_t;

  // One shift-and-add-three step: correct every BCD digit of five or more,
  // then shift the next binary bit into the BCD field.
  function automatic sidac_item_t dd_step(input sidac_item_t it);
    sidac_item_t r;
    logic [DigitW-1:0] dig;
    r = it;
    for (int i = 0; i < NumDigits; i++) begin
      dig = r.bcd[i*DigitW +: DigitW];
      if (dig >= 4'd5) begin
        r.bcd[i*DigitW +: DigitW] = dig + 4'd3;
      end
    end
    r.bcd = {r.bcd[BcdW-2:0], r.bin[ValueW-1]};
    r.bin = {r.bin[ValueW-2:0], 1'b0};
    return r;
  endfunction

endpackage

/* hdl/sidac_front.sv */
// Input register stage: splits the two's complement value into a sign
// flag and a 32-bit magnitude. Depends on sidac_pkg.
module sidac_front
  import sidac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sidac_item_t       item_o
);

  logic        valid_q;
  sidac_item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Magnitude of the most negative value still fits in 32 unsigned bits.
  always_comb begin
    item_d.neg = value_i[ValueW-1];
    item_d.bin = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;
    item_d.bcd = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/sidac_dd_stage.sv */
// One pipeline stage of the binary to BCD converter: a group of
// shift-and-add-three steps followed by a register. Depends on sidac_pkg.
module sidac_dd_stage
  import sidac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  sidac_item_t item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output sidac_item_t item_o
);

  logic        valid_q;
  sidac_item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Chain of steps over the narrow BCD digits.
  always_comb begin
    item_d = item_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      item_d = dd_step(item_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/sidac_emit.sv */
// Output serialiser: holds one converted number and sends its sign and
// significant digits one character per word. Depends on sidac_pkg.
module sidac_emit
  import sidac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sidac_item_t      item_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [CharW-1:0] char_o,
  output logic             last_o
);

  logic                               busy_q, busy_d;
  logic                               sign_q, sign_d;
  logic [DigitIdxW-1:0]               idx_q, idx_d;
  logic [NumDigits-1:0][DigitW-1:0]   dig_q;
  logic [NumDigits-1:0][DigitW-1:0]   dig_in;
  logic [DigitIdxW-1:0]               top_idx;
  logic                               out_fire;
  logic                               finish;
  logic                               load;

  assign dig_in = item_i.bcd;

  // Position of the highest non-zero digit; zero keeps the units digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (dig_in[i] != '0) begin
        top_idx = DigitIdxW'(i);
      end
    end
  end

  assign out_fire = busy_q && ready_i;
  assign finish   = out_fire && !sign_q && (idx_q == '0);
  assign ready_o  = !busy_q || finish;
  assign load     = ready_o && valid_i;

  // Current character from the held state.
  assign valid_o = busy_q;
  assign char_o  = sign_q ? AsciiMinus : (AsciiZero + CharW'(dig_q[idx_q]));
  assign last_o  = !sign_q && (idx_q == '0);

  // Walk from sign to most significant digit down to the units digit.
  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    if (out_fire) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      sign_d = item_i.neg;
      idx_d  = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= dig_in;
    end
  end

endmodule

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// Signed 32-bit integer to decimal ASCII text, one character per output
// word, most significant first, with a leading minus sign for negative
// values, no leading zeros (zero gives "0"), and tlast on the units digit.
// A value passes a sign/magnitude stage and four binary-to-BCD stages of
// eight shift-and-add-three steps each, then reaches the output serialiser,
// which holds it and sends one character per cycle while m_axis_tready is
// high, one to eleven characters per number. With the pipeline full, a new
// number is taken in the same cycle that its predecessor's last character
// leaves. Depends on sidac_pkg, sidac_front, sidac_dd_stage and sidac_emit.
module signed_int_to_decimal_ascii_unit
  import sidac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [31:0] value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] character
  output logic             m_axis_tlast    // last_char
);

  logic        valid_s [NumDdStages+1];
  logic        ready_s [NumDdStages+1];
  sidac_item_t item_s  [NumDdStages+1];

  // Sign and magnitude.
  sidac_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .item_o  (item_s[0])
  );

  // Binary to BCD pipeline.
  for (genvar g = 0; g < NumDdStages; g++) begin : g_dd
    sidac_dd_stage u_dd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .item_i  (item_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .item_o  (item_s[g+1])
    );
  end

  // Character serialiser.
  sidac_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NumDdStages]),
    .ready_o (ready_s[NumDdStages]),
    .item_i  (item_s[NumDdStages]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule
